FILE: design/mscd_pkg.sv
// Shared types, codes and constants of the countdown timer table.
package mscd_pkg;

  // Field widths fixed by the interface
  localparam int RATE_W  = 14;
  localparam int MS_W    = 16;
  localparam int WORD_W  = 32;
  localparam int SLOT_W  = 4;
  localparam int TICKS_W = 20;

  // Millisecond to tick conversion: multiply the product by ceil(2^38 / 1000)
  // and drop 38 bits; the quotient is exact for every product below 2^30
  localparam int MS_PER_S    = 1000;
  localparam int PROD_W      = RATE_W + MS_W;
  localparam int RECIP_W     = 29;
  localparam int RECIP_SHIFT = 38;
  localparam int SCALED_W    = PROD_W + RECIP_W;
  localparam int QUOT_W      = SCALED_W - RECIP_SHIFT;
  localparam logic [RECIP_W-1:0] RECIP_1000 = 29'd274877907;
  localparam logic [TICKS_W-1:0] TICKS_MAX  = {TICKS_W{1'b1}};

  // Request opcodes
  localparam logic [1:0] OP_REGISTER   = 2'd0;
  localparam logic [1:0] OP_UNREGISTER = 2'd1;
  localparam logic [1:0] OP_TICK       = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_REGISTER   = 2'd0;
  localparam logic [1:0] KIND_UNREGISTER = 2'd1;
  localparam logic [1:0] KIND_EXPIRY     = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [SLOT_W-1:0] slot;
    logic              ok;
    logic [WORD_W-1:0] tag;
    logic [WORD_W-1:0] word;
    logic [SLOT_W-1:0] active;
    logic              last;
  } result_t;

  // Low four bits of a count or slot number
  function automatic logic [SLOT_W-1:0] low_nibble(input logic [31:0] v);
    return v[SLOT_W-1:0];
  endfunction

endpackage

FILE: design/mscd_div.sv
// Shared converter: milliseconds to ticks by a product and a reciprocal multiply.
module mscd_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  logic [mscd_pkg::RATE_W-1:0]   rate,
  input  logic [mscd_pkg::MS_W-1:0]     ms,
  output logic                          done,
  output logic [mscd_pkg::TICKS_W-1:0]  ticks
);

  logic                           scale_pend;
  logic [mscd_pkg::PROD_W-1:0]    prod;
  logic [mscd_pkg::SCALED_W-1:0]  scaled;
  logic [mscd_pkg::QUOT_W-1:0]    quot;

  // Track the two multiply stages and flag the quotient
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_pend <= 1'b0;
      done       <= 1'b0;
    end else begin
      scale_pend <= load;
      done       <= scale_pend;
    end
  end

  // Form rate times interval, then scale it by the reciprocal of 1000
  always_ff @(posedge clk) begin
    if (load) begin
      prod <= mscd_pkg::PROD_W'(rate) * mscd_pkg::PROD_W'(ms);
    end
    if (scale_pend) begin
      scaled <= mscd_pkg::SCALED_W'(prod) * mscd_pkg::SCALED_W'(mscd_pkg::RECIP_1000);
    end
  end

  // Keep the integer part of the scaled product
  assign quot = scaled[mscd_pkg::SCALED_W-1:mscd_pkg::RECIP_SHIFT];

  // Clamp to at least one tick and at most the counter range
  always_comb begin
    if (quot == '0) begin
      ticks = mscd_pkg::TICKS_W'(1);
    end else if (quot[mscd_pkg::QUOT_W-1]) begin
      ticks = mscd_pkg::TICKS_MAX;
    end else begin
      ticks = quot[mscd_pkg::TICKS_W-1:0];
    end
  end

endmodule

FILE: design/multi_slot_countdown_timers_core.sv
// Top level of the countdown timer table: slot storage, sequencer and result register.
//
//  Channel   Signals                                            Handshake
//  --------  -------------------------------------------------  ------------------------
//  request   opcode timeout_ms periodic handler_tag user_word   start high, busy low
//            slot_id_in
//  result    reply_kind slot_number success handler_tag_out     result_valid, one cycle
//            user_word_out active_slots tick_total last_of_run
//  config    cfg_data (tick_rate_hz)                            cfg_write
//
// Unregister requests and rejected registrations never raise busy; their reply
// appears in the next cycle. A registration holds busy while the shared
// converter forms the rate times interval product and then multiplies it by the
// reciprocal of 1000; the slot is written and the reply registered when the
// converter flags its quotient.
// A tick walks the slots one per cycle, expiries leaving through a one-entry hold
// so the last one can be marked.
// Reset clears the active flags, the count and the tick counter.
// The receiver cannot stall results.
module multi_slot_countdown_timers_core #(
  parameter int SLOT_COUNT = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [mscd_pkg::RATE_W-1:0]   cfg_data,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    opcode,
  input  logic [mscd_pkg::MS_W-1:0]     timeout_ms,
  input  logic                          periodic,
  input  logic [mscd_pkg::WORD_W-1:0]   handler_tag,
  input  logic [mscd_pkg::WORD_W-1:0]   user_word,
  input  logic [7:0]                    slot_id_in,
  output logic                          result_valid,
  output logic [1:0]                    reply_kind,
  output logic [mscd_pkg::SLOT_W-1:0]   slot_number,
  output logic                          success,
  output logic [mscd_pkg::WORD_W-1:0]   handler_tag_out,
  output logic [mscd_pkg::WORD_W-1:0]   user_word_out,
  output logic [mscd_pkg::SLOT_W-1:0]   active_slots,
  output logic [63:0]                   tick_total,
  output logic                          last_of_run
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);

  // Slot storage
  logic [SLOT_COUNT-1:0]         slot_active;
  logic                          slot_periodic  [SLOT_COUNT];
  logic [mscd_pkg::TICKS_W-1:0]  slot_interval  [SLOT_COUNT];
  logic [mscd_pkg::TICKS_W-1:0]  slot_remaining [SLOT_COUNT];
  logic [mscd_pkg::WORD_W-1:0]   slot_handler   [SLOT_COUNT];
  logic [mscd_pkg::WORD_W-1:0]   slot_user      [SLOT_COUNT];

  // Control and pending registration
  mscd_pkg::state_t              state, state_next;
  logic [mscd_pkg::RATE_W-1:0]   tick_rate_hz;
  logic [63:0]                   tick_count;
  logic [CNT_W-1:0]              active_count, active_count_next;
  logic [IDX_W-1:0]              idx;
  logic [IDX_W-1:0]              pend_idx;
  logic                          pend_periodic;
  logic [mscd_pkg::WORD_W-1:0]   pend_tag;
  logic [mscd_pkg::WORD_W-1:0]   pend_word;
  logic                          hold_valid;
  mscd_pkg::result_t             hold;
  mscd_pkg::result_t             out_res;

  // Decode signals
  logic                          accept;
  logic                          free_found;
  logic [IDX_W-1:0]              free_idx;
  logic                          reg_ok;
  logic                          unreg_in_range;
  logic [7:0]                    sid_m1;
  logic [IDX_W-1:0]              sid_idx;
  logic [mscd_pkg::TICKS_W-1:0]  rem_dec;
  logic                          expire;
  logic                          div_load;
  logic                          div_done;
  logic [mscd_pkg::TICKS_W-1:0]  div_ticks;

  // Sequencer actions
  logic                          emit;
  mscd_pkg::result_t             emit_res;
  logic                          do_claim;
  logic                          do_unreg;
  logic                          do_tick;
  logic                          do_expire;
  logic                          hold_clear;

  assign busy   = (state != mscd_pkg::ST_IDLE);
  assign accept = start && !busy;

  // Find the lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!slot_active[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  assign reg_ok = (handler_tag != '0) && (timeout_ms != '0) && (tick_rate_hz != '0)
                  && free_found;
  assign unreg_in_range = (slot_id_in != 8'd0) && ({24'd0, slot_id_in} <= 32'(SLOT_COUNT));
  assign sid_m1  = slot_id_in - 8'd1;
  assign sid_idx = sid_m1[IDX_W-1:0];
  assign rem_dec = slot_remaining[idx] - 1'b1;
  assign expire  = slot_active[idx] && (rem_dec == '0);

  // Next state, result and slot actions
  always_comb begin
    state_next        = state;
    active_count_next = active_count;
    emit              = 1'b0;
    emit_res          = hold;
    div_load          = 1'b0;
    do_claim          = 1'b0;
    do_unreg          = 1'b0;
    do_tick           = 1'b0;
    do_expire         = 1'b0;
    hold_clear        = 1'b0;
    unique case (state)
      mscd_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (opcode)
            mscd_pkg::OP_REGISTER: begin
              if (reg_ok) begin
                div_load   = 1'b1;
                state_next = mscd_pkg::ST_DIV;
              end else begin
                emit     = 1'b1;
                emit_res = '{kind: mscd_pkg::KIND_REGISTER, slot: '0, ok: 1'b0,
                             tag: '0, word: '0,
                             active: mscd_pkg::low_nibble(32'(active_count)),
                             last: 1'b1};
              end
            end
            mscd_pkg::OP_UNREGISTER: begin
              do_unreg = unreg_in_range && slot_active[sid_idx];
              if (do_unreg) begin
                active_count_next = active_count - 1'b1;
              end
              emit     = 1'b1;
              emit_res = '{kind: mscd_pkg::KIND_UNREGISTER,
                           slot: unreg_in_range ? slot_id_in[mscd_pkg::SLOT_W-1:0] : '0,
                           ok: do_unreg, tag: '0, word: '0,
                           active: mscd_pkg::low_nibble(32'(active_count_next)),
                           last: 1'b1};
            end
            mscd_pkg::OP_TICK: begin
              do_tick    = 1'b1;
              state_next = mscd_pkg::ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      mscd_pkg::ST_DIV: begin
        if (div_done) begin
          do_claim          = 1'b1;
          active_count_next = active_count + 1'b1;
          emit              = 1'b1;
          emit_res = '{kind: mscd_pkg::KIND_REGISTER,
                       slot: mscd_pkg::low_nibble(32'(pend_idx) + 32'd1), ok: 1'b1,
                       tag: '0, word: '0,
                       active: mscd_pkg::low_nibble(32'(active_count_next)),
                       last: 1'b1};
          state_next = mscd_pkg::ST_IDLE;
        end
      end
      mscd_pkg::ST_SCAN: begin
        if (expire) begin
          do_expire = 1'b1;
          if (!slot_periodic[idx]) begin
            active_count_next = active_count - 1'b1;
          end
          emit = hold_valid;
        end
        if (idx == IDX_W'(SLOT_COUNT - 1)) begin
          state_next = mscd_pkg::ST_FLUSH;
        end
      end
      mscd_pkg::ST_FLUSH: begin
        emit          = hold_valid;
        emit_res.last = 1'b1;
        hold_clear    = 1'b1;
        state_next    = mscd_pkg::ST_IDLE;
      end
      default: begin
        state_next = mscd_pkg::ST_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= mscd_pkg::ST_IDLE;
      tick_rate_hz <= '0;
      tick_count   <= '0;
      active_count <= '0;
      slot_active  <= '0;
      hold_valid   <= 1'b0;
      result_valid <= 1'b0;
      idx          <= '0;
    end else begin
      state        <= state_next;
      active_count <= active_count_next;
      result_valid <= emit;
      if (cfg_write) begin
        tick_rate_hz <= cfg_data;
      end
      if (do_tick) begin
        tick_count <= tick_count + 64'd1;
        idx        <= '0;
      end else if (state == mscd_pkg::ST_SCAN) begin
        idx <= idx + 1'b1;
      end
      if (do_claim) begin
        slot_active[pend_idx] <= 1'b1;
      end
      if (do_unreg) begin
        slot_active[sid_idx] <= 1'b0;
      end
      if (do_expire && !slot_periodic[idx]) begin
        slot_active[idx] <= 1'b0;
      end
      if (do_expire) begin
        hold_valid <= 1'b1;
      end else if (hold_clear) begin
        hold_valid <= 1'b0;
      end
    end
  end

  // Latch the pending registration while the converter runs
  always_ff @(posedge clk) begin
    if (div_load) begin
      pend_idx      <= free_idx;
      pend_periodic <= periodic;
      pend_tag      <= handler_tag;
      pend_word     <= user_word;
    end
  end

  // Write slot payload: claim, count down or reload
  always_ff @(posedge clk) begin
    if (do_claim) begin
      slot_periodic[pend_idx]  <= pend_periodic;
      slot_interval[pend_idx]  <= div_ticks;
      slot_remaining[pend_idx] <= div_ticks;
      slot_handler[pend_idx]   <= pend_tag;
      slot_user[pend_idx]      <= pend_word;
    end
    if (state == mscd_pkg::ST_SCAN && slot_active[idx]) begin
      if (expire && slot_periodic[idx]) begin
        slot_remaining[idx] <= slot_interval[idx];
      end else begin
        slot_remaining[idx] <= rem_dec;
      end
    end
  end

  // Park the newest expiry until the next one or the end of the walk
  always_ff @(posedge clk) begin
    if (do_expire) begin
      hold <= '{kind: mscd_pkg::KIND_EXPIRY,
                slot: mscd_pkg::low_nibble(32'(idx) + 32'd1), ok: 1'b1,
                tag: slot_handler[idx], word: slot_user[idx],
                active: mscd_pkg::low_nibble(32'(active_count_next)),
                last: 1'b0};
    end
  end

  // Register the outgoing result
  always_ff @(posedge clk) begin
    if (emit) begin
      out_res <= emit_res;
    end
  end

  mscd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .load  (div_load),
    .rate  (tick_rate_hz),
    .ms    (timeout_ms),
    .done  (div_done),
    .ticks (div_ticks)
  );

  assign reply_kind      = out_res.kind;
  assign slot_number     = out_res.slot;
  assign success         = out_res.ok;
  assign handler_tag_out = out_res.tag;
  assign user_word_out   = out_res.word;
  assign active_slots    = out_res.active;
  assign last_of_run     = out_res.last;
  assign tick_total      = tick_count;

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the countdown timer table: directed table, then random phases.
module tb;

  localparam int SLOTS         = 8;
  localparam int RUN_LIMIT     = 200000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS   = 20;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]                  op;
    logic [mscd_pkg::MS_W-1:0]   ms;
    logic                        periodic;
    logic [mscd_pkg::WORD_W-1:0] tag;
    logic [mscd_pkg::WORD_W-1:0] word;
    logic [7:0]                  sid;
  } timer_req_t;

  typedef struct packed {
    logic [1:0]                  kind;
    logic [mscd_pkg::SLOT_W-1:0] slot;
    logic                        ok;
    logic [mscd_pkg::WORD_W-1:0] tag;
    logic [mscd_pkg::WORD_W-1:0] word;
    logic [mscd_pkg::SLOT_W-1:0] active;
    logic [63:0]                 ticks;
    logic                        last;
  } timer_event_t;

  typedef enum logic {ROW_REQUEST, ROW_RATE} row_kind_t;

  typedef struct packed {
    row_kind_t                   kind;
    logic [mscd_pkg::RATE_W-1:0] rate;
    timer_req_t                  req;
    logic                        pinned;
    logic [1:0]                  pin_kind;
    logic [mscd_pkg::SLOT_W-1:0] pin_slot;
    logic                        pin_ok;
  } plan_row_t;

  logic                          clk;
  logic                          rst;
  logic                          cfg_write;
  logic [mscd_pkg::RATE_W-1:0]   cfg_data;
  logic                          start;
  logic                          busy;
  logic [1:0]                    opcode;
  logic [mscd_pkg::MS_W-1:0]     timeout_ms;
  logic                          periodic;
  logic [mscd_pkg::WORD_W-1:0]   handler_tag;
  logic [mscd_pkg::WORD_W-1:0]   user_word;
  logic [7:0]                    slot_id_in;
  logic                          result_valid;
  logic [1:0]                    reply_kind;
  logic [mscd_pkg::SLOT_W-1:0]   slot_number;
  logic                          success;
  logic [mscd_pkg::WORD_W-1:0]   handler_tag_out;
  logic [mscd_pkg::WORD_W-1:0]   user_word_out;
  logic [mscd_pkg::SLOT_W-1:0]   active_slots;
  logic [63:0]                   tick_total;
  logic                          last_of_run;

  // Reply fixed by hand for the request currently offered
  logic                          pin_en;
  logic [1:0]                    pin_kind;
  logic [mscd_pkg::SLOT_W-1:0]   pin_slot;
  logic                          pin_ok;

  // Timer table as the testbench sees it
  logic [mscd_pkg::RATE_W-1:0]   rate_m;
  logic [SLOTS-1:0]              live;
  logic [SLOTS-1:0]              reload;
  logic [mscd_pkg::TICKS_W-1:0]  interval_t [SLOTS];
  logic [mscd_pkg::TICKS_W-1:0]  remaining_t [SLOTS];
  logic [mscd_pkg::WORD_W-1:0]   handler_m [SLOTS];
  logic [mscd_pkg::WORD_W-1:0]   user_m [SLOTS];
  logic [63:0]                   ticks_m;

  timer_event_t        expected_events [$];
  plan_row_t           plan [$];
  int                  errors = 0;
  int                  cycles = 0;

  multi_slot_countdown_timers_core #(.SLOT_COUNT(SLOTS)) dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .start(start), .busy(busy), .opcode(opcode), .timeout_ms(timeout_ms),
    .periodic(periodic), .handler_tag(handler_tag), .user_word(user_word),
    .slot_id_in(slot_id_in), .result_valid(result_valid), .reply_kind(reply_kind),
    .slot_number(slot_number), .success(success), .handler_tag_out(handler_tag_out),
    .user_word_out(user_word_out), .active_slots(active_slots),
    .tick_total(tick_total), .last_of_run(last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [mscd_pkg::SLOT_W-1:0] live_count();
    logic [mscd_pkg::SLOT_W-1:0] n;
    n = '0;
    for (int i = 0; i < SLOTS; i++) n = n + live[i];
    return n;
  endfunction

  function automatic timer_event_t timer_event(input logic [1:0] kind,
                                               input logic [mscd_pkg::SLOT_W-1:0] slot,
                                               input logic ok,
                                               input logic [mscd_pkg::WORD_W-1:0] tag,
                                               input logic [mscd_pkg::WORD_W-1:0] word);
    timer_event_t e;
    e.kind   = kind;
    e.slot   = slot;
    e.ok     = ok;
    e.tag    = tag;
    e.word   = word;
    e.active = live_count();
    e.ticks  = ticks_m;
    e.last   = 1'b1;
    return e;
  endfunction

  // Apply one request to the table and queue the replies and expiries it causes
  function automatic void advance_timers(input timer_req_t r);
    logic [63:0]                 t;
    logic [mscd_pkg::SLOT_W-1:0] slot;
    logic                        ok;
    logic                        held_valid;
    timer_event_t                held;
    slot = '0;
    ok = 1'b0;
    held_valid = 1'b0;
    held = '0;
    case (r.op)
      mscd_pkg::OP_REGISTER: begin
        if (r.tag != 0 && r.ms != 0 && rate_m != 0) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (!live[i] && slot == 0) begin
              t = rate_m;
              t = t * r.ms / mscd_pkg::MS_PER_S;
              if (t == 0) t = 1;
              if (t > mscd_pkg::TICKS_MAX) t = mscd_pkg::TICKS_MAX;
              handler_m[i]   = r.tag;
              user_m[i]      = r.word;
              interval_t[i]  = t[mscd_pkg::TICKS_W-1:0];
              remaining_t[i] = t[mscd_pkg::TICKS_W-1:0];
              reload[i]      = r.periodic;
              live[i]        = 1'b1;
              slot           = mscd_pkg::SLOT_W'(i + 1);
            end
          end
        end
        expected_events.push_back(timer_event(mscd_pkg::KIND_REGISTER, slot, slot != 0,
                                              '0, '0));
      end
      mscd_pkg::OP_UNREGISTER: begin
        if (r.sid != 0 && r.sid <= SLOTS) begin
          slot = r.sid[mscd_pkg::SLOT_W-1:0];
          if (live[r.sid - 1]) begin
            live[r.sid - 1] = 1'b0;
            ok = 1'b1;
          end
        end
        expected_events.push_back(timer_event(mscd_pkg::KIND_UNREGISTER, slot, ok, '0, '0));
      end
      mscd_pkg::OP_TICK: begin
        ticks_m = ticks_m + 1;
        // Hold each expiry back one slot so the final one can be marked last
        for (int i = 0; i < SLOTS; i++) begin
          if (live[i]) begin
            remaining_t[i] = remaining_t[i] - 1'b1;
            if (remaining_t[i] == 0) begin
              if (reload[i]) remaining_t[i] = interval_t[i];
              else live[i] = 1'b0;
              if (held_valid) begin
                held.last = 1'b0;
                expected_events.push_back(held);
              end
              held = timer_event(mscd_pkg::KIND_EXPIRY, mscd_pkg::SLOT_W'(i + 1), 1'b1,
                                 handler_m[i], user_m[i]);
              held_valid = 1'b1;
            end
          end
        end
        if (held_valid) expected_events.push_back(held);
      end
      default: ;
    endcase
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Check results against the oldest expectation, then track config and requests
  always @(posedge clk) begin : monitor
    timer_event_t want;
    timer_req_t   seen;
    if (rst) begin
      rate_m  = '0;
      live    = '0;
      ticks_m = '0;
    end else begin
      if (result_valid) begin
        if (expected_events.size() == 0) begin
          $display("%0t: unexpected result kind %0d slot %0d", $time, reply_kind,
                   slot_number);
          errors++;
        end else begin
          want = expected_events.pop_front();
          check_field("reply_kind", want.kind, reply_kind);
          check_field("slot_number", want.slot, slot_number);
          check_field("success", want.ok, success);
          check_field("handler_tag_out", want.tag, handler_tag_out);
          check_field("user_word_out", want.word, user_word_out);
          check_field("active_slots", want.active, active_slots);
          check_field("tick_total", want.ticks, tick_total);
          check_field("last_of_run", want.last, last_of_run);
        end
      end
      if (cfg_write) rate_m = cfg_data;
      if (start && !busy) begin
        seen = {opcode, timeout_ms, periodic, handler_tag, user_word, slot_id_in};
        advance_timers(seen);
        // Replace the predicted reply kind, slot and success flag with the ones fixed in the table
        if (pin_en) begin
          want = expected_events.pop_back();
          want.kind = pin_kind;
          want.slot = pin_slot;
          want.ok   = pin_ok;
          expected_events.push_back(want);
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == RUN_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  function automatic void plan_req(input logic [1:0] op, input int ms, input logic per,
                                   input logic [mscd_pkg::WORD_W-1:0] tag,
                                   input logic [mscd_pkg::WORD_W-1:0] word, input int sid,
                                   input logic pinned, input logic [1:0] pk,
                                   input int ps, input logic po);
    plan_row_t row;
    row = '0;
    row.kind         = ROW_REQUEST;
    row.req.op       = op;
    row.req.ms       = mscd_pkg::MS_W'(ms);
    row.req.periodic = per;
    row.req.tag      = tag;
    row.req.word     = word;
    row.req.sid      = 8'(sid);
    row.pinned       = pinned;
    row.pin_kind     = pk;
    row.pin_slot     = mscd_pkg::SLOT_W'(ps);
    row.pin_ok       = po;
    plan.push_back(row);
  endfunction

  function automatic void plan_rate(input int v);
    plan_row_t row;
    row = '0;
    row.kind = ROW_RATE;
    row.rate = mscd_pkg::RATE_W'(v);
    plan.push_back(row);
  endfunction

  function automatic timer_req_t random_request(input int rate);
    timer_req_t r;
    int roll;
    int short_ms;
    roll = $urandom_range(99);
    if (roll < 40) r.op = mscd_pkg::OP_TICK;
    else if (roll < 75) r.op = mscd_pkg::OP_REGISTER;
    else if (roll < 95) r.op = mscd_pkg::OP_UNREGISTER;
    else r.op = OP_UNUSED;
    // Mostly intervals of a few ticks so slots expire within the phase
    short_ms = (rate == 0) ? 5000 : 5000 / rate + 1;
    roll = $urandom_range(99);
    if (roll < 5) r.ms = '0;
    else if (roll < 10) r.ms = '1;
    else if (roll < 25) r.ms = mscd_pkg::MS_W'($urandom);
    else r.ms = mscd_pkg::MS_W'($urandom_range(short_ms, 1));
    roll = $urandom_range(99);
    if (roll < 6) r.tag = '0;
    else if (roll < 10) r.tag = '1;
    else r.tag = $urandom;
    r.word = $urandom;
    r.periodic = $urandom_range(1);
    roll = $urandom_range(99);
    if (roll < 10) r.sid = 8'($urandom_range(255));
    else r.sid = 8'($urandom_range(SLOTS, 1));
    return r;
  endfunction

  // Offer a request and hold it until the block takes it
  task automatic send_request(input timer_req_t r, input logic pinned, input logic [1:0] pk,
                              input logic [mscd_pkg::SLOT_W-1:0] ps, input logic po);
    start       <= 1'b1;
    opcode      <= r.op;
    timeout_ms  <= r.ms;
    periodic    <= r.periodic;
    handler_tag <= r.tag;
    user_word   <= r.word;
    slot_id_in  <= r.sid;
    pin_en      <= pinned;
    pin_kind    <= pk;
    pin_slot    <= ps;
    pin_ok      <= po;
    do @(posedge clk); while (busy);
  endtask

  task automatic sender_gap(input int pct);
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Wait for every outstanding result, then let a quiet tick or a conversion finish
  task automatic drain_and_settle();
    start <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_tick_rate(input int v);
    drain_and_settle();
    cfg_write <= 1'b1;
    cfg_data  <= mscd_pkg::RATE_W'(v);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    plan_row_t row;
    int        rates [5];
    int        idle_pct [5];
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_data = '0;
    start = 1'b0;
    opcode = '0;
    timeout_ms = '0;
    periodic = 1'b0;
    handler_tag = '0;
    user_word = '0;
    slot_id_in = '0;
    pin_en = 1'b0;
    pin_kind = '0;
    pin_slot = '0;
    pin_ok = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Rate zero after reset: every registration fails, bad slot ids, quiet tick
    plan_req(mscd_pkg::OP_REGISTER, 100, 0, 1, 0, 0, 1, mscd_pkg::KIND_REGISTER, 0, 0);
    plan_req(mscd_pkg::OP_UNREGISTER, 0, 0, 0, 0, 0, 1, mscd_pkg::KIND_UNREGISTER, 0, 0);
    plan_req(mscd_pkg::OP_UNREGISTER, 0, 0, 0, 0, 8, 1, mscd_pkg::KIND_UNREGISTER, 8, 0);
    plan_req(mscd_pkg::OP_UNREGISTER, 0, 0, 0, 0, 9, 1, mscd_pkg::KIND_UNREGISTER, 0, 0);
    plan_req(mscd_pkg::OP_UNREGISTER, 0, 0, 0, 0, 255, 1, mscd_pkg::KIND_UNREGISTER, 0, 0);
    plan_req(mscd_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    plan_req(OP_UNUSED, 65535, 1, '1, '1, 255, 0, 0, 0, 0);
    // Slowest rate: intervals round down to the one-tick floor
    plan_rate(1);
    plan_req(mscd_pkg::OP_REGISTER, 0, 0, 1, 0, 0, 1, mscd_pkg::KIND_REGISTER, 0, 0);
    plan_req(mscd_pkg::OP_REGISTER, 65535, 0, 0, 0, 0, 1, mscd_pkg::KIND_REGISTER, 0, 0);
    plan_req(mscd_pkg::OP_REGISTER, 1, 0, '1, '1, 0, 1, mscd_pkg::KIND_REGISTER, 1, 1);
    plan_req(mscd_pkg::OP_REGISTER, 1999, 1, 32'h8000_0001, 32'h5A5A_5A5A, 0, 1,
             mscd_pkg::KIND_REGISTER, 2, 1);
    plan_req(mscd_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    plan_req(mscd_pkg::OP_REGISTER, 1500, 1, 2, 0, 0, 1, mscd_pkg::KIND_REGISTER, 1, 1);
    plan_req(mscd_pkg::OP_REGISTER, 1000, 0, 3, 33, 0, 0, 0, 0, 0);
    plan_req(mscd_pkg::OP_REGISTER, 1000, 1, 4, 44, 0, 0, 0, 0, 0);
    plan_req(mscd_pkg::OP_REGISTER, 1000, 0, 5, 55, 0, 0, 0, 0, 0);
    plan_req(mscd_pkg::OP_REGISTER, 1000, 1, 6, 66, 0, 0, 0, 0, 0);
    plan_req(mscd_pkg::OP_REGISTER, 1000, 0, 7, 77, 0, 0, 0, 0, 0);
    plan_req(mscd_pkg::OP_REGISTER, 500, 1, 8, 88, 0, 0, 0, 0, 0);
    // Table full, then every slot expires on one tick
    plan_req(mscd_pkg::OP_REGISTER, 1, 0, 9, 99, 0, 1, mscd_pkg::KIND_REGISTER, 0, 0);
    plan_req(mscd_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    plan_req(mscd_pkg::OP_UNREGISTER, 0, 0, 0, 0, 2, 1, mscd_pkg::KIND_UNREGISTER, 2, 1);
    plan_req(mscd_pkg::OP_UNREGISTER, 0, 0, 0, 0, 2, 1, mscd_pkg::KIND_UNREGISTER, 2, 0);
    // Fastest rate with the longest interval
    plan_rate(10000);
    plan_req(mscd_pkg::OP_REGISTER, 65535, 0, 32'h7FFF_FFFF, 1, 0, 0, 0, 0, 0);

    for (int k = 0; k < plan.size(); k++) begin
      row = plan[k];
      if (row.kind == ROW_RATE) set_tick_rate(row.rate);
      else send_request(row.req, row.pinned, row.pin_kind, row.pin_slot, row.pin_ok);
    end

    // Random phases: each with its own rate and sender idling
    rates[0] = 1;
    rates[1] = $urandom_range(999, 2);
    rates[2] = 10000;
    rates[3] = $urandom_range(9999, 1000);
    rates[4] = 0;
    idle_pct[0] = 0;
    idle_pct[1] = 75;
    idle_pct[2] = 0;
    idle_pct[3] = 33;
    idle_pct[4] = 0;
    for (int p = 0; p < 5; p++) begin
      set_tick_rate(rates[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Hold off mid-phase until the table has answered everything
        if (n == PHASE_ITEMS / 2) drain_and_settle();
        send_request(random_request(rates[p]), 1'b0, '0, '0, 1'b0);
        sender_gap(idle_pct[p]);
      end
    end

    start <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
